>>> rtl/trh_pkg.sv
// ----------------------------------------------------------------------------
// trh_pkg
// Shared types and constants for the room heat step block: register indexes,
// command codes, configuration bundle and result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package trh_pkg;

  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int TEMP_W     = 16;
  localparam int DB_W       = 15;
  localparam int POWER_W    = 16;
  localparam int COEF_W     = 16;
  localparam int GAIN_W     = 24;
  localparam int MINUTE_W   = 11;
  localparam int ENERGY_W   = 27;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SET_TEMP      = 3'd0,
    REG_DEADBAND      = 3'd1,
    REG_HEATER_POWER  = 3'd2,
    REG_THERMO_EN     = 3'd3,
    REG_OUTSIDE_TEMP  = 3'd4,
    REG_DECAY_COEFF   = 3'd5,
    REG_HEAT_GAIN     = 3'd6,
    REG_INTERVAL_MIN  = 3'd7
  } reg_idx_t;

  typedef enum logic {
    CMD_ADVANCE = 1'b0,
    CMD_LOAD    = 1'b1
  } cmd_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] set_temp;
    logic [DB_W-1:0]          deadband;
    logic [POWER_W-1:0]       heater_power;
    logic                     thermostat_enabled;
    logic signed [TEMP_W-1:0] outside_temp;
    logic [COEF_W-1:0]        decay_coeff;
    logic [GAIN_W-1:0]        heat_gain;
    logic [MINUTE_W-1:0]      interval_minutes;
  } cfg_t;

  typedef struct packed {
    logic                     heater_on;
    logic [POWER_W-1:0]       power_out;
    logic signed [TEMP_W-1:0] room_temp;
    logic [ENERGY_W-1:0]      interval_energy;
    logic [POWER_W-1:0]       interval_peak;
    logic [MINUTE_W-1:0]      peak_minute;
    logic                     interval_done;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/trh_cfg.sv
// ----------------------------------------------------------------------------
// trh_cfg
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
`default_nettype none

module trh_cfg
  import trh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  we,
  input  wire logic [CFG_IDX_W-1:0]  index,
  input  wire logic [CFG_DATA_W-1:0] wdata,
  output cfg_t                       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.set_temp           <= 16'sd5376;
      cfg_r.deadband           <= 15'd576;
      cfg_r.heater_power       <= 16'd1500;
      cfg_r.thermostat_enabled <= 1'b1;
      cfg_r.outside_temp       <= 16'sd2560;
      cfg_r.decay_coeff        <= 16'd65455;
      cfg_r.heat_gain          <= 24'd2000;
      cfg_r.interval_minutes   <= 11'd15;
    end else if (we) begin
      unique case (reg_idx_t'(index))
        REG_SET_TEMP:     cfg_r.set_temp           <= $signed(wdata[TEMP_W-1:0]);
        REG_DEADBAND:     cfg_r.deadband           <= wdata[DB_W-1:0];
        REG_HEATER_POWER: cfg_r.heater_power       <= wdata[POWER_W-1:0];
        REG_THERMO_EN:    cfg_r.thermostat_enabled <= wdata[0];
        REG_OUTSIDE_TEMP: cfg_r.outside_temp       <= $signed(wdata[TEMP_W-1:0]);
        REG_DECAY_COEFF:  cfg_r.decay_coeff        <= wdata[COEF_W-1:0];
        REG_HEAT_GAIN:    cfg_r.heat_gain          <= wdata[GAIN_W-1:0];
        REG_INTERVAL_MIN: cfg_r.interval_minutes   <= wdata[MINUTE_W-1:0];
        default:          cfg_r.set_temp           <= cfg_r.set_temp;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> rtl/trh_core.sv
// ----------------------------------------------------------------------------
// trh_core
// Room state, temperature load and one-minute step: hysteresis flag, thermal
// update with rounding and saturation, interval energy and peak tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module trh_core
  import trh_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     step_en,
  input  wire logic                     cmd,
  input  wire logic signed [TEMP_W-1:0] load_temp,
  output res_t                          res
);

  logic                     flag_r,   flag_nxt;
  logic signed [TEMP_W-1:0] temp_r,   temp_nxt;
  logic [MINUTE_W-1:0]      minute_r, minute_nxt;
  logic [ENERGY_W-1:0]      energy_r, energy_nxt;
  logic [POWER_W-1:0]       peak_r,   peak_nxt;
  logic [MINUTE_W-1:0]      ptime_r,  ptime_nxt;

  logic signed [TEMP_W+1:0] above, below, db_s;
  logic                     adv_flag;
  logic [POWER_W-1:0]       power;
  logic [COEF_W:0]          inv_decay;
  logic signed [32:0]       p_room;
  logic signed [33:0]       p_out;
  logic [GAIN_W+POWER_W-1:0] p_heat;
  logic signed [42:0]       acc;
  logic signed [26:0]       rnd;
  logic signed [TEMP_W-1:0] adv_temp;
  logic [ENERGY_W-1:0]      base_energy;
  logic [POWER_W-1:0]       base_peak;
  logic [MINUTE_W-1:0]      base_ptime;
  logic [ENERGY_W:0]        energy_sum;
  logic [ENERGY_W-1:0]      adv_energy;
  logic [POWER_W-1:0]       adv_peak;
  logic [MINUTE_W-1:0]      adv_ptime, minute_inc;
  logic                     adv_done;

  always_comb begin
    // hysteresis on the current temperature
    above    = 18'(temp_r) - 18'(cfg.set_temp);
    below    = 18'(cfg.set_temp) - 18'(temp_r);
    db_s     = $signed({3'b000, cfg.deadband});
    adv_flag = flag_r;
    if (flag_r && (above > db_s)) adv_flag = 1'b0;
    if (!flag_r && (below > db_s)) adv_flag = 1'b1;
    power = (adv_flag || !cfg.thermostat_enabled) ? cfg.heater_power : '0;

    // thermal model in Q.24
    inv_decay = 17'h10000 - {1'b0, cfg.decay_coeff};
    p_room    = $signed({1'b0, cfg.decay_coeff}) * temp_r;
    p_out     = $signed({1'b0, inv_decay}) * cfg.outside_temp;
    p_heat    = cfg.heat_gain * power;
    acc       = 43'(p_room) + 43'(p_out) + $signed({3'b000, p_heat}) + 43'sd32768;
    rnd       = acc[42:16];
    if (rnd > 27'sd32767)       adv_temp = 16'sh7fff;
    else if (rnd < -27'sd32768) adv_temp = 16'sh8000;
    else                        adv_temp = rnd[TEMP_W-1:0];

    // interval accumulators clear at the first minute
    base_energy = (minute_r == '0) ? '0 : energy_r;
    base_peak   = (minute_r == '0) ? '0 : peak_r;
    base_ptime  = (minute_r == '0) ? '0 : ptime_r;
    energy_sum  = {1'b0, base_energy} + (ENERGY_W+1)'(power);
    adv_energy  = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];
    minute_inc  = minute_r + 11'd1;
    adv_peak    = base_peak;
    adv_ptime   = base_ptime;
    if (power > base_peak) begin
      adv_peak  = power;
      adv_ptime = minute_inc;
    end
    adv_done = (minute_inc >= cfg.interval_minutes) || (minute_inc == '0);

    flag_nxt   = flag_r;
    temp_nxt   = temp_r;
    minute_nxt = minute_r;
    energy_nxt = energy_r;
    peak_nxt   = peak_r;
    ptime_nxt  = ptime_r;
    unique case (cmd_t'(cmd))
      CMD_LOAD: begin
        temp_nxt = load_temp;
        res.power_out     = '0;
        res.interval_done = 1'b0;
      end
      CMD_ADVANCE: begin
        flag_nxt   = adv_flag;
        temp_nxt   = adv_temp;
        minute_nxt = adv_done ? '0 : minute_inc;
        energy_nxt = adv_energy;
        peak_nxt   = adv_peak;
        ptime_nxt  = adv_ptime;
        res.power_out     = power;
        res.interval_done = adv_done;
      end
      default: begin
        res.power_out     = '0;
        res.interval_done = 1'b0;
      end
    endcase
    res.heater_on       = flag_nxt;
    res.room_temp       = temp_nxt;
    res.interval_energy = energy_nxt;
    res.interval_peak   = peak_nxt;
    res.peak_minute     = ptime_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r   <= 1'b0;
      temp_r   <= 16'sd5376;
      minute_r <= '0;
      energy_r <= '0;
      peak_r   <= '0;
      ptime_r  <= '0;
    end else if (step_en) begin
      flag_r   <= flag_nxt;
      temp_r   <= temp_nxt;
      minute_r <= minute_nxt;
      energy_r <= energy_nxt;
      peak_r   <= peak_nxt;
      ptime_r  <= ptime_nxt;
    end
  end

  // a recorded peak always has a nonzero minute and vice versa
  a_peak_time_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (peak_r == '0) == (ptime_r == '0))
    else $error("peak power and peak minute disagree");

  // the minute counter never sits at or past a nonzero interval end after a step
  a_minute_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (cmd_t'(cmd) == CMD_ADVANCE) && adv_done |=> (minute_r == '0))
    else $error("minute counter did not return to zero at interval end");

  // load leaves the interval bookkeeping alone
  a_load_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (cmd_t'(cmd) == CMD_LOAD) |=> $stable(minute_r) && $stable(energy_r)
    && $stable(flag_r))
    else $error("load request disturbed interval state");

endmodule

`default_nettype wire

>>> rtl/thermostat_room_heat_step.sv
// ----------------------------------------------------------------------------
// thermostat_room_heat_step
// Thermostat-controlled room heater, one simulated minute per advance request,
// with interval energy and peak accounting.
// ----------------------------------------------------------------------------
//   channel | ports                                   | direction
//   in      | in_valid, in_stall, in_command, in_load_temp | request in
//   out     | out_valid, out_stall, out_* result fields    | result out
//   cfg     | cfg_we, cfg_index, cfg_wdata                 | register write
//
// one request per cycle while out_stall is low; results are registered;
// three multiplies (17x16, 18x16, 24x16) feed a four-term add
// synchronous active-low reset restores valid flags, config and core state
// in_stall rises only when the input register is full and the result
// register is held by out_stall
`default_nettype none

module thermostat_room_heat_step
  import trh_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_command,
  input  wire logic signed [TEMP_W-1:0]  in_load_temp,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_heater_on,
  output logic [POWER_W-1:0]             out_power_out,
  output logic signed [TEMP_W-1:0]       out_room_temp,
  output logic [ENERGY_W-1:0]            out_interval_energy,
  output logic [POWER_W-1:0]             out_interval_peak,
  output logic [MINUTE_W-1:0]            out_peak_minute,
  output logic                           out_interval_done
);

  cfg_t cfg_q;
  res_t res, res_r;

  logic                     s1_valid_r, s1_valid_nxt;
  logic                     s1_cmd_r;
  logic signed [TEMP_W-1:0] s1_load_r;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_free, s1_adv, in_take;

  trh_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg_q)
  );

  trh_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_q),
    .step_en   (s1_adv),
    .cmd       (s1_cmd_r),
    .load_temp (s1_load_r),
    .res       (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_command;
      s1_load_r <= in_load_temp;
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_heater_on       = res_r.heater_on;
  assign out_power_out       = res_r.power_out;
  assign out_room_temp       = res_r.room_temp;
  assign out_interval_energy = res_r.interval_energy;
  assign out_interval_peak   = res_r.interval_peak;
  assign out_peak_minute     = res_r.peak_minute;
  assign out_interval_done   = res_r.interval_done;

  // a staged request always lands in the result register when it is free
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("staged request was not moved to the result register");

  // stall back-pressure only when the input register is occupied
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room to spare");

  // heat only flows when the flag or a disabled thermostat allows it
  a_power_gated: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_r.power_out != '0) |-> res_r.heater_on
    || !cfg_q.thermostat_enabled)
    else $error("power reported while thermostat flag is off");

endmodule

`default_nettype wire
